// File: rtl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rau_pkg.sv
package rau_pkg;
    localparam int W = 32;
    localparam int DW = W - 1;
    localparam int PW = 2 * W + 1;
    localparam int CW = $clog2(PW + 1);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_INV = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic comb;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic is_zero;
        logic gcd_done;
        logic div_last;
        logic div_done;
    } t_stat;
endpackage

// File: rtl/rau_datapath.sv
module rau_datapath (
    input  logic                i_clk,
    input  rau_pkg::t_cmd       i_cmd,
    output rau_pkg::t_stat      o_stat,
    input  logic [2:0]          i_command,
    input  logic [rau_pkg::W-1:0]  i_lhs_num,
    input  logic [rau_pkg::DW-1:0] i_lhs_den,
    input  logic [rau_pkg::W-1:0]  i_rhs_num,
    input  logic [rau_pkg::DW-1:0] i_rhs_den,
    output logic [rau_pkg::W-1:0]  o_res_num,
    output logic [rau_pkg::DW-1:0] o_res_den,
    output logic [1:0]          o_status
);
    import rau_pkg::*;

    logic [2:0] r_cmd;
    logic signed [W-1:0] r_a, r_x;
    logic [DW-1:0] r_b, r_y;
    logic signed [2*W-1:0] r_p1, r_p2, r_pd;
    logic signed [PW-1:0] r_n;
    logic [PW-1:0] r_un, r_ud, r_gu, r_gv, r_q, r_rem, r_dvs;
    logic r_neg, r_which;
    logic [CW-1:0] r_shift, r_cnt;
    logic [PW-1:0] r_qn;
    logic [PW:0] n_trial;
    logic [PW-1:0] n_diff;
    logic signed [2*W-1:0] n_m1, n_m2;
    logic signed [W:0] n_ma, n_mb, n_mc, n_md;
    logic bypass;

    always_comb begin
        bypass = 1'b0;
        if (r_cmd > CMD_INV) begin
            bypass = 1'b1;
        end else if (r_b == '0 || (r_cmd != CMD_INV && r_y == '0)) begin
            bypass = 1'b1;
        end else if (r_cmd == CMD_DIV && r_x == '0) begin
            bypass = 1'b1;
        end else if (r_cmd == CMD_INV && r_a == '0) begin
            bypass = 1'b1;
        end
    end

    always_comb begin
        n_ma = {r_a[W-1], r_a};
        n_mb = $signed({2'b00, r_y});
        n_mc = $signed({2'b00, r_b});
        n_md = {r_x[W-1], r_x};
        if (r_cmd == CMD_MUL) n_mb = {r_x[W-1], r_x};
        if (i_cmd.mul2) begin
            n_ma = $signed({2'b00, r_b});
            n_mb = (r_cmd == CMD_DIV) ? {r_x[W-1], r_x} : $signed({2'b00, r_y});
        end
        n_m1 = (2*W)'(n_ma * n_mb);
        n_m2 = (2*W)'(n_mc * n_md);
    end

    assign n_diff = r_gu - r_gv;
    assign n_trial = {r_rem, r_qn[PW-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_a <= i_lhs_num;
            r_b <= i_lhs_den;
            r_x <= i_rhs_num;
            r_y <= i_rhs_den;
        end
        if (i_cmd.mul1) begin
            r_p1 <= n_m1;
            r_p2 <= n_m2;
        end
        if (i_cmd.mul2) r_pd <= n_m1;
        if (i_cmd.comb) begin
            unique case (r_cmd)
                CMD_ADD: r_n <= PW'(r_p1) + PW'(r_p2);
                CMD_SUB: r_n <= PW'(r_p1) - PW'(r_p2);
                CMD_INV: r_n <= $signed({{(PW-DW){1'b0}}, r_b});
                default: r_n <= PW'(r_p1);
            endcase
            if (r_cmd == CMD_INV) begin
                r_pd <= (2*W)'(r_a);
            end
        end
        if (i_cmd.gcd_init) begin
            r_neg <= r_n[PW-1] ^ r_pd[2*W-1];
            r_un <= r_n[PW-1] ? PW'(-r_n) : PW'(r_n);
            r_ud <= r_pd[2*W-1] ? PW'(-PW'(r_pd)) : PW'(r_pd);
            r_gu <= r_n[PW-1] ? PW'(-r_n) : PW'(r_n);
            r_gv <= r_pd[2*W-1] ? PW'(-PW'(r_pd)) : PW'(r_pd);
            r_shift <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_gu[0] && !r_gv[0]) begin
                r_gu <= r_gu >> 1;
                r_gv <= r_gv >> 1;
                r_shift <= r_shift + CW'(1);
            end else if (!r_gu[0]) begin
                r_gu <= r_gu >> 1;
            end else if (!r_gv[0]) begin
                r_gv <= r_gv >> 1;
            end else if (r_gu >= r_gv) begin
                r_gu <= n_diff >> 1;
            end else begin
                r_gv <= (r_gv - r_gu) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_dvs <= r_gv << r_shift;
            r_rem <= '0;
            r_qn <= r_which ? r_ud : r_un;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!n_trial[PW]) r_rem <= n_trial[PW-1:0];
            else r_rem <= {r_rem[PW-2:0], r_qn[PW-1]};
            r_qn <= {r_qn[PW-2:0], ~n_trial[PW]};
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(PW - 1)) begin
                if (r_which) r_ud <= {r_qn[PW-2:0], ~n_trial[PW]};
                else r_un <= {r_qn[PW-2:0], ~n_trial[PW]};
            end
        end
        if (i_cmd.gcd_init) r_which <= 1'b0;
        else if (i_cmd.div_step && r_cnt == CW'(PW - 1)) r_which <= ~r_which;
        if (i_cmd.fin) begin
            if (bypass) begin
                o_res_num <= r_a;
                o_res_den <= r_b;
                o_status <= (r_cmd > CMD_INV) ? ST_OK : ST_ZERO;
            end else if (r_n == '0) begin
                o_res_num <= '0;
                o_res_den <= DW'(1);
                o_status <= ST_OK;
            end else begin
                o_res_num <= r_neg ? W'(-r_un) : W'(r_un);
                o_res_den <= DW'(r_ud);
                if ((r_neg ? (r_un > (PW'(1) << (W-1)))
                           : (r_un > ((PW'(1) << (W-1)) - PW'(1))))
                    || r_ud > PW'({DW{1'b1}})) begin
                    o_status <= ST_OVF;
                end else begin
                    o_status <= ST_OK;
                end
            end
        end
    end

    assign o_stat.bypass = bypass;
    assign o_stat.is_zero = (r_n == '0);
    assign o_stat.gcd_done = (r_gu == r_gv) || (r_gu == '0) || (r_gv == '0);
    assign o_stat.div_last = (r_cnt == CW'(PW - 1));
    assign o_stat.div_done = (r_cnt == CW'(PW - 1)) && r_which;
endmodule

// File: rtl/rau_ctrl.sv
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_COMB = 4'd3;
    localparam logic [3:0] S_GINIT = 4'd4;
    localparam logic [3:0] S_GCD = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;

    logic [3:0] r_state, n_state;
    logic r_valid, n_valid;
    logic load;

    assign o_in_ready = (r_state == S_IDLE) && (!r_valid || i_out_ready);
    assign load = i_in_valid && o_in_ready;
    assign o_out_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_valid = r_valid;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = load;
                if (load) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state = (i_stat.bypass) ? S_FIN : S_GINIT;
            end
            S_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state = i_stat.is_zero ? S_FIN : S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) n_state = S_DINIT;
                else o_cmd.gcd_step = 1'b1;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_FIN;
                else if (i_stat.div_last) n_state = S_DINIT;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule

// File: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit.
// The slave channel takes one word holding a command and two fractions; the
// master channel returns the reduced fraction and a status code.
// Input tdata, from bit 0: command[2:0], lhs_num[31:0], lhs_den[30:0],
// rhs_num[31:0], rhs_den[30:0], zero fill to 136 bits.
// Output tdata, from bit 0: res_num[31:0], res_den[30:0], status[1:0],
// zero fill to 72 bits.
// One word is worked on at a time. The controller steps through MUL1, MUL2,
// COMB, GINIT, GCD, DINIT, DIV and FIN. Bypassed cases (unknown command, zero
// denominator, zero divisor) go from COMB to FIN and return the lhs fraction
// unchanged; a zero numerator goes from GINIT to FIN. Otherwise a binary gcd
// loop over the 65-bit magnitudes and two bit-serial exact divisions run.
// The result sits in an output register; a new word is taken once the
// datapath is idle and that register is free or being drained.
// When the receiver stalls, tvalid and tdata hold until tready is seen.
// Synchronous active-low reset clears the controller and output valid.
module rational_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, lhs_num, lhs_den, rhs_num, rhs_den from bit 0
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num, res_den, status from bit 0
    output logic [71:0]  m_axis_tdata
);
    import rau_pkg::*;
`include "rational_arithmetic_unit_assert.svh"

    t_cmd cmd;
    t_stat stat;
    logic [W-1:0] res_num;
    logic [DW-1:0] res_den;
    logic [1:0] status;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    rau_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .o_stat(stat),
        .i_command(s_axis_tdata[2:0]),
        .i_lhs_num(s_axis_tdata[34:3]),
        .i_lhs_den(s_axis_tdata[65:35]),
        .i_rhs_num(s_axis_tdata[97:66]),
        .i_rhs_den(s_axis_tdata[128:98]),
        .o_res_num(res_num), .o_res_den(res_den), .o_status(status)
    );

    assign m_axis_tdata = {7'b0, status, res_den, res_num};

    `RAU_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n,
        cmd.mul1 || cmd.gcd_step || cmd.div_step, !s_axis_tready,
        "input accepted while busy")
    `RAU_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, cmd.fin, m_axis_tvalid,
        "result not presented after finish")
    `RAU_ASSERT_IMP(a_status_range, i_clk, i_rst_n, m_axis_tvalid, status != 2'd3,
        "illegal status code")
endmodule
